>>> rtl/anchor_containment_dedup_defines.svh
// ---------------------------------------------------------------------------
// anchor_containment_dedup_defines.svh
// Assertion macros shared by the anchor dedup checker.
// ---------------------------------------------------------------------------
`ifndef ANCHOR_CONTAINMENT_DEDUP_DEFINES_SVH
`define ANCHOR_CONTAINMENT_DEDUP_DEFINES_SVH

// implication in the same cycle, disabled during reset
`define ACD_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication into the next cycle, disabled during reset
`define ACD_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// implication into the next cycle, active during reset
`define ACD_ASSERT_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/acd_pkg.sv
// ---------------------------------------------------------------------------
// acd_pkg
// Types and constants for the anchor containment dedup block.
// ---------------------------------------------------------------------------
`default_nettype none

package acd_pkg;

   localparam int WINDOW = 100;

   localparam int SID_W  = 31;
   localparam int LEN_W  = 24;
   localparam int QPOS_W = 24;
   localparam int TPOS_W = 40;
   // target start = end + 1 - len, signed, spans -2^24+2 .. 2^40
   localparam int TS_W   = TPOS_W + 2;
   // diagonal = target end - query end
   localparam int DIAG_W = TPOS_W + 1;

   localparam logic KIND_ANCHOR = 1'b0;
   localparam logic KIND_DRAIN  = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [SID_W-1:0]  anchor_sid;
      logic [LEN_W-1:0]  anchor_len;
      logic [QPOS_W-1:0] anchor_qpos;
      logic [TPOS_W-1:0] anchor_tpos;
   } req_type;

   typedef struct packed {
      logic [SID_W-1:0]  kept_sid;
      logic [LEN_W-1:0]  kept_len;
      logic [QPOS_W-1:0] kept_qpos;
      logic [TPOS_W-1:0] kept_tpos;
   } rsp_type;

   // new anchor as broadcast to every cell
   typedef struct packed {
      logic                    drain;
      logic [SID_W-1:0]        sid;
      logic [LEN_W-1:0]        len;
      logic [QPOS_W-1:0]       qpos;
      logic [TPOS_W-1:0]       tpos;
      logic signed [TS_W-1:0]  ts;
      logic [DIAG_W-1:0]       diag;
   } bcast_type;

   // one window slot
   typedef struct packed {
      logic                    valid;
      logic                    dropped;
      logic [SID_W-1:0]        sid;
      logic [LEN_W-1:0]        len;
      logic [QPOS_W-1:0]       qpos;
      logic [TPOS_W-1:0]       tpos;
      logic signed [TS_W-1:0]  ts;
      logic [DIAG_W-1:0]       diag;
   } entry_type;

endpackage

`default_nettype wire

>>> rtl/acd_cell.sv
// ---------------------------------------------------------------------------
// acd_cell
// One window slot: compares against the broadcast anchor and shifts onward.
// ---------------------------------------------------------------------------
`default_nettype none

module acd_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               shift_en,
   input  acd_pkg::bcast_type      bcast,
   input  acd_pkg::entry_type      entry_up,
   output acd_pkg::entry_type      entry_down,
   output logic                    new_hit
);
   import acd_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;
   logic      starts_later;
   logic      mark;

   always_comb begin
      match = entry_ff.valid && !bcast.drain && (entry_ff.sid == bcast.sid) &&
              ($signed({2'b00, entry_ff.tpos}) >= bcast.ts);
      starts_later = (entry_ff.ts >= bcast.ts);
      // same diagonal: start offsets equal in target and query
      mark = match && starts_later && (entry_ff.diag == bcast.diag);
      new_hit = match && !starts_later && (entry_ff.tpos == bcast.tpos) &&
                (entry_ff.qpos == bcast.qpos);
   end

   always_comb begin
      entry_down = entry_ff;
      entry_down.dropped = entry_ff.dropped | mark;
   end

   always_comb begin
      entry_in = shift_en ? entry_up : entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/anchor_containment_dedup.sv
// ---------------------------------------------------------------------------
// anchor_containment_dedup
// Sliding-window removal of contained and duplicate seed anchors.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries anchors (kind = anchor) sorted by id and target end, or
//   drain items (kind = drain) that push an empty slot to flush the window.
//   rsp_* carries each surviving anchor as it leaves the window.
//   A transfer on req_ is registered into a broadcast stage, against which
//   every window cell compares; when rsp_ is not stalled the chain shifts by
//   one and the evicted slot, if valid and not dropped, lands in the output
//   register. Throughput: one item per cycle while rsp_ is not stalled. An
//   anchor itself leaves the window WINDOW items after its transfer.
//   Reset empties all slots and the broadcast and output stages; no clearing
//   pass is needed. While rsp_ is stalled the chain holds and req_ready drops
//   once the broadcast stage is full.
// ---------------------------------------------------------------------------
`default_nettype none

module anchor_containment_dedup (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  acd_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output acd_pkg::rsp_type   rsp_data
);
   import acd_pkg::*;

   bcast_type bc_ff;
   bcast_type bc_in;
   logic      bc_valid_ff;
   logic      bc_valid_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;

   logic      advance;
   logic      req_xfer;

   entry_type chain [WINDOW+1];
   logic [WINDOW-1:0] hits;

   assign advance   = bc_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !bc_valid_ff || advance;
   assign req_xfer  = req_valid && req_ready;

   always_comb begin
      bc_in       = bc_ff;
      bc_valid_in = bc_valid_ff && !advance;
      if (req_xfer) begin
         bc_valid_in = 1'b1;
         bc_in.drain = (req_data.kind == KIND_DRAIN);
         bc_in.sid   = req_data.anchor_sid;
         bc_in.len   = req_data.anchor_len;
         bc_in.qpos  = req_data.anchor_qpos;
         bc_in.tpos  = req_data.anchor_tpos;
         bc_in.ts    = $signed({2'b00, req_data.anchor_tpos} + TS_W'(1)
                               - {{(TS_W-LEN_W){1'b0}}, req_data.anchor_len});
         bc_in.diag  = {1'b0, req_data.anchor_tpos}
                       - {{(DIAG_W-QPOS_W){1'b0}}, req_data.anchor_qpos};
      end
   end

   // entry written into the head of the chain
   always_comb begin
      chain[0].valid   = !bc_ff.drain;
      chain[0].dropped = |hits;
      chain[0].sid     = bc_ff.sid;
      chain[0].len     = bc_ff.len;
      chain[0].qpos    = bc_ff.qpos;
      chain[0].tpos    = bc_ff.tpos;
      chain[0].ts      = bc_ff.ts;
      chain[0].diag    = bc_ff.diag;
   end

   for (genvar g = 0; g < WINDOW; g++) begin : g_cell
      acd_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (advance),
         .bcast      (bc_ff),
         .entry_up   (chain[g]),
         .entry_down (chain[g+1]),
         .new_hit    (hits[g])
      );
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = chain[WINDOW].valid && !chain[WINDOW].dropped;
         rsp_data_in.kept_sid  = chain[WINDOW].sid;
         rsp_data_in.kept_len  = chain[WINDOW].len;
         rsp_data_in.kept_qpos = chain[WINDOW].qpos;
         rsp_data_in.kept_tpos = chain[WINDOW].tpos;
      end
   end

   always_ff @(posedge clock) begin
      bc_ff       <= bc_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         bc_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bc_valid_ff  <= bc_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> rtl/acd_checker.sv
// ---------------------------------------------------------------------------
// acd_checker
// Port-level checks for anchor_containment_dedup, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "anchor_containment_dedup_defines.svh"

module acd_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_ready,
   input  wire logic          rsp_valid,
   input  wire logic          rsp_ready,
   input  acd_pkg::rsp_type   rsp_data
);
   import acd_pkg::*;

   logic    req_xfer;
   logic    rsp_stall;
   logic    fill_stall;
   rsp_type rsp_seen;

   assign req_xfer   = req_valid && req_ready;
   assign rsp_stall  = rsp_valid && !rsp_ready;
   assign fill_stall = req_xfer && rsp_stall;
   assign rsp_seen   = rsp_data;

   // a stalled result holds
   `ACD_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_seen), "stalled result changed")

   // reset leaves no result pending
   `ACD_ASSERT_RST(a_rsp_reset, reset, !rsp_valid, "result valid after reset")

   // with the output stage empty the block always takes input
   `ACD_ASSERT_IMP(a_ready_free, !rsp_valid, req_ready, "input blocked with empty output")

   // a transfer while the output is stalled fills the input stage
   `ACD_ASSERT_NXT(a_fill_stall, fill_stall, !req_ready || rsp_ready, "input stage overrun")

endmodule

bind anchor_containment_dedup acd_checker u_acd_checker (.*);

`default_nettype wire
